>>> rtl/peshp_pkg.sv
`default_nettype none

package peshp_pkg;

   // fixed field widths
   localparam int CMD_W     = 2;
   localparam int BYTE_W    = 8;
   localparam int IDX_IN_W  = 4;
   localparam int TS_W      = 33;
   localparam int PLEN_W    = 24;
   localparam int CNT_W     = 5;
   localparam int HLEN_W    = 6;
   localparam int PKTLEN_W  = 16;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int PC_W      = 5;

   localparam int PRIVATE_MAX_DEF = 16;
   localparam logic [CNT_W-1:0] STUFF_MAX = 5'd28;

   localparam logic [BYTE_W-1:0] SID_NO_EXT   = 8'hBF;
   localparam logic [BYTE_W-1:0] PRIV_MARKER  = 8'b1000_1110;
   localparam logic [BYTE_W-1:0] STUFF_BYTE   = 8'hFF;
   localparam logic [PKTLEN_W:0] PKTLEN_LIMIT = 17'h0FFFF;

   // input commands
   localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_HEADER  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PAYLOAD = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STREAM_ID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALIGN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STUFFING  = 2'd2;

   // microprogram entry points
   localparam logic [PC_W-1:0] ADDR_HEADER  = 5'd0;
   localparam logic [PC_W-1:0] ADDR_TS_PTS  = 5'd9;
   localparam logic [PC_W-1:0] ADDR_TS_DTS  = 5'd14;
   localparam logic [PC_W-1:0] ADDR_PRIV    = 5'd19;
   localparam logic [PC_W-1:0] ADDR_STUFF   = 5'd21;
   localparam logic [PC_W-1:0] ADDR_PAYLOAD = 5'd22;

   typedef enum logic [4:0] {
      SRC_ZERO,
      SRC_ONE,
      SRC_SID,
      SRC_LENH,
      SRC_LENL,
      SRC_FLAG0,
      SRC_FLAGS,
      SRC_HLEN,
      SRC_TS0,
      SRC_TS1,
      SRC_TS2,
      SRC_TS3,
      SRC_TS4,
      SRC_PRIVHDR,
      SRC_PRIV,
      SRC_STUFF,
      SRC_DATA
   } byte_src_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_EXTRA,
      COND_PTS,
      COND_DTS,
      COND_PRIV,
      COND_STUFF
   } cond_type;

   typedef enum logic [2:0] {
      TAIL_NEVER,
      TAIL_ALWAYS,
      TAIL_LEN,
      TAIL_HLEN,
      TAIL_PTS,
      TAIL_DTS,
      TAIL_PRIV
   } tail_type;

   typedef enum logic [1:0] {
      REP_NONE,
      REP_PRIV,
      REP_STUFF
   } rep_type;

   typedef struct packed {
      byte_src_type    src;
      logic            use_dts;
      cond_type        cond;
      tail_type        tail;
      rep_type         rep;
      logic [PC_W-1:0] skip_to;
   } ucode_type;

   // sequencer to datapath
   typedef struct packed {
      byte_src_type     src;
      logic             use_dts;
      logic [CNT_W-1:0] cnt;
   } seq_ctrl_type;

   // datapath to sequencer, per-run flags
   typedef struct packed {
      logic             extra;
      logic             has_pts;
      logic             send_dts;
      logic             has_priv;
      logic             has_stuff;
      logic [CNT_W-1:0] priv_len;
      logic [CNT_W-1:0] stuff_len;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/peshp_ucode_rom.sv
`default_nettype none

module peshp_ucode_rom (
   input  wire logic [peshp_pkg::PC_W-1:0] addr,
   output peshp_pkg::ucode_type            word
);
   import peshp_pkg::*;

   function automatic ucode_type uw(byte_src_type s, logic d, cond_type c, tail_type t,
                                    rep_type r, logic [PC_W-1:0] k);
      ucode_type w;
      w.src     = s;
      w.use_dts = d;
      w.cond    = c;
      w.tail    = t;
      w.rep     = r;
      w.skip_to = k;
      return w;
   endfunction

   always_comb begin
      unique case (addr)
         // start code, stream id, packet length
         5'd0:  word = uw(SRC_ZERO, 1'b0, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd1:  word = uw(SRC_ZERO, 1'b0, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd2:  word = uw(SRC_ONE,  1'b0, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd3:  word = uw(SRC_SID,  1'b0, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd4:  word = uw(SRC_LENH, 1'b0, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd5:  word = uw(SRC_LENL, 1'b0, COND_ALWAYS, TAIL_LEN,   REP_NONE, ADDR_HEADER);
         // optional header bytes
         5'd6:  word = uw(SRC_FLAG0, 1'b0, COND_EXTRA, TAIL_NEVER, REP_NONE, ADDR_TS_PTS);
         5'd7:  word = uw(SRC_FLAGS, 1'b0, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd8:  word = uw(SRC_HLEN,  1'b0, COND_ALWAYS, TAIL_HLEN,  REP_NONE, ADDR_HEADER);
         // pts
         5'd9:  word = uw(SRC_TS0, 1'b0, COND_PTS,    TAIL_NEVER, REP_NONE, ADDR_TS_DTS);
         5'd10: word = uw(SRC_TS1, 1'b0, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd11: word = uw(SRC_TS2, 1'b0, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd12: word = uw(SRC_TS3, 1'b0, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd13: word = uw(SRC_TS4, 1'b0, COND_ALWAYS, TAIL_PTS,   REP_NONE, ADDR_HEADER);
         // dts
         5'd14: word = uw(SRC_TS0, 1'b1, COND_DTS,    TAIL_NEVER, REP_NONE, ADDR_PRIV);
         5'd15: word = uw(SRC_TS1, 1'b1, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd16: word = uw(SRC_TS2, 1'b1, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd17: word = uw(SRC_TS3, 1'b1, COND_ALWAYS, TAIL_NEVER, REP_NONE, ADDR_HEADER);
         5'd18: word = uw(SRC_TS4, 1'b1, COND_ALWAYS, TAIL_DTS,   REP_NONE, ADDR_HEADER);
         // private data
         5'd19: word = uw(SRC_PRIVHDR, 1'b0, COND_PRIV, TAIL_NEVER, REP_NONE, ADDR_STUFF);
         5'd20: word = uw(SRC_PRIV, 1'b0, COND_ALWAYS, TAIL_PRIV, REP_PRIV, ADDR_HEADER);
         // stuffing, always ends the run
         5'd21: word = uw(SRC_STUFF, 1'b0, COND_STUFF, TAIL_ALWAYS, REP_STUFF, ADDR_HEADER);
         // payload pass-through
         5'd22: word = uw(SRC_DATA, 1'b0, COND_ALWAYS, TAIL_ALWAYS, REP_NONE, ADDR_HEADER);
         default: word = uw(SRC_ZERO, 1'b0, COND_ALWAYS, TAIL_ALWAYS, REP_NONE, ADDR_HEADER);
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/peshp_sequencer.sv
`default_nettype none

module peshp_sequencer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start_hdr,
   input  wire logic                     start_pay,
   input  wire logic                     out_free,
   input  peshp_pkg::dp_status_type      status,
   output peshp_pkg::seq_ctrl_type       ctrl,
   output logic                          emit,
   output logic                          last,
   output logic                          busy,
   output logic                          done_now
);
   import peshp_pkg::*;

   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   ucode_type        word;
   logic             cond_ok, final_iter, tail_last;
   logic             t_stuff, t_priv, t_dts, t_pts;

   peshp_ucode_rom u_rom (
      .addr (pc_ff),
      .word (word)
   );

   // is anything left after each section
   assign t_stuff = status.has_stuff;
   assign t_priv  = status.has_priv | t_stuff;
   assign t_dts   = status.send_dts | t_priv;
   assign t_pts   = status.has_pts | t_dts;

   always_comb begin
      unique case (word.cond)
         COND_ALWAYS: cond_ok = 1'b1;
         COND_EXTRA:  cond_ok = status.extra;
         COND_PTS:    cond_ok = status.has_pts;
         COND_DTS:    cond_ok = status.send_dts;
         COND_PRIV:   cond_ok = status.has_priv;
         COND_STUFF:  cond_ok = status.has_stuff;
         default:     cond_ok = 1'b1;
      endcase
   end

   always_comb begin
      unique case (word.tail)
         TAIL_NEVER:  tail_last = 1'b0;
         TAIL_ALWAYS: tail_last = 1'b1;
         TAIL_LEN:    tail_last = ~status.extra & ~t_pts;
         TAIL_HLEN:   tail_last = ~t_pts;
         TAIL_PTS:    tail_last = ~t_dts;
         TAIL_DTS:    tail_last = ~t_priv;
         TAIL_PRIV:   tail_last = ~t_stuff;
         default:     tail_last = 1'b1;
      endcase
   end

   always_comb begin
      unique case (word.rep)
         REP_NONE:  final_iter = 1'b1;
         REP_PRIV:  final_iter = (cnt_ff + CNT_W'(1)) == status.priv_len;
         REP_STUFF: final_iter = (cnt_ff + CNT_W'(1)) == status.stuff_len;
         default:   final_iter = 1'b1;
      endcase
   end

   assign emit     = busy_ff & cond_ok & out_free;
   assign last     = tail_last & final_iter;
   assign done_now = emit & last;
   assign busy     = busy_ff;

   assign ctrl.src     = word.src;
   assign ctrl.use_dts = word.use_dts;
   // count of the coming step, lets the private buffer read register load ahead of that step
   assign ctrl.cnt     = cnt_in;

   always_comb begin
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start_hdr || start_pay) begin
         busy_in = 1'b1;
         pc_in   = start_pay ? ADDR_PAYLOAD : ADDR_HEADER;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (!cond_ok) begin
            pc_in  = word.skip_to;
            cnt_in = '0;
         end else if (out_free) begin
            if (last) begin
               busy_in = 1'b0;
            end else if (!final_iter) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               pc_in  = pc_ff + PC_W'(1);
               cnt_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= ADDR_HEADER;
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      emit |-> busy_ff)
      else $error("byte emitted while sequencer idle");

   a_priv_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && word.rep == REP_PRIV) |-> (cnt_ff < status.priv_len))
      else $error("private read past requested length");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (done_now && !start_hdr && !start_pay) |=> !busy_ff)
      else $error("sequencer still busy after last byte");

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start_hdr || start_pay) |-> (!busy_ff || done_now))
      else $error("run started over an unfinished run");

endmodule

`default_nettype wire

>>> rtl/peshp_datapath.sv
`default_nettype none

module peshp_datapath #(
   parameter int PRIVATE_MAX = peshp_pkg::PRIVATE_MAX_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             start_hdr,
   input  wire logic                             start_pay,
   input  wire logic                             load,
   input  wire logic [peshp_pkg::BYTE_W-1:0]     data_byte,
   input  wire logic [peshp_pkg::IDX_IN_W-1:0]   byte_index,
   input  wire logic                             has_pts,
   input  wire logic [peshp_pkg::TS_W-1:0]       pts_value,
   input  wire logic                             has_dts,
   input  wire logic [peshp_pkg::TS_W-1:0]       dts_value,
   input  wire logic [peshp_pkg::PLEN_W-1:0]     payload_length,
   input  wire logic [peshp_pkg::CNT_W-1:0]      private_length,
   input  wire logic [peshp_pkg::BYTE_W-1:0]     stream_id,
   input  wire logic                             data_alignment,
   input  wire logic [peshp_pkg::CNT_W-1:0]      stuffing_length,
   input  peshp_pkg::seq_ctrl_type               ctrl,
   output peshp_pkg::dp_status_type              status,
   output logic [peshp_pkg::BYTE_W-1:0]          out_byte
);
   import peshp_pkg::*;

   localparam int IDX_W = (PRIVATE_MAX > 1) ? $clog2(PRIVATE_MAX) : 1;

   logic [BYTE_W-1:0]   priv_mem [PRIVATE_MAX];
   logic [BYTE_W-1:0]   priv_rd_ff;

   logic [BYTE_W-1:0]   data_ff;
   logic                has_pts_ff, send_dts_ff;
   logic [TS_W-1:0]     pts_ff, dts_ff;
   logic [PLEN_W-1:0]   plen_ff;
   logic [CNT_W-1:0]    priv_ff, stuff_ff;
   logic [HLEN_W-1:0]   hlen_ff, hlen_in;
   logic [PKTLEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0]    priv_sat, stuff_sat;
   logic                extra;
   logic [PLEN_W:0]     len_sum;
   logic [TS_W-1:0]     ts;
   logic [3:0]          ts_nib;

   assign priv_sat  = (private_length > CNT_W'(PRIVATE_MAX)) ? CNT_W'(PRIVATE_MAX)
                                                             : private_length;
   assign stuff_sat = (stuffing_length > STUFF_MAX) ? STUFF_MAX : stuffing_length;
   assign extra     = stream_id != SID_NO_EXT;

   // private buffer write on load transactions
   always_ff @(posedge clock) begin
      if (load && ({1'b0, byte_index} < (IDX_IN_W + 1)'(PRIVATE_MAX))) begin
         priv_mem[byte_index[IDX_W-1:0]] <= data_byte;
      end
   end

   // registered read, addressed by the count of the coming step
   always_ff @(posedge clock) begin
      priv_rd_ff <= priv_mem[ctrl.cnt[IDX_W-1:0]];
   end

   // per-item fields, captured at acceptance
   always_ff @(posedge clock) begin
      if (start_pay) begin
         data_ff <= data_byte;
      end
      if (start_hdr) begin
         has_pts_ff  <= has_pts;
         send_dts_ff <= has_pts & has_dts & (dts_value != pts_value);
         pts_ff      <= pts_value;
         dts_ff      <= dts_value;
         plen_ff     <= payload_length;
         priv_ff     <= priv_sat;
         stuff_ff    <= stuff_sat;
      end
      hlen_ff <= hlen_in;
      len_ff  <= len_in;
   end

   // header length registered from the captured fields, packet length registered from the header length
   always_comb begin
      hlen_in = HLEN_W'(stuff_ff);
      if (has_pts_ff)  hlen_in = hlen_in + HLEN_W'(5);
      if (send_dts_ff) hlen_in = hlen_in + HLEN_W'(5);
      if (priv_ff != '0) hlen_in = hlen_in + HLEN_W'(priv_ff) + HLEN_W'(1);
   end

   assign len_sum = {1'b0, plen_ff} + (PLEN_W + 1)'(hlen_ff) +
                    (extra ? (PLEN_W + 1)'(3) : '0);
   assign len_in  = ((plen_ff == '0) || (len_sum > (PLEN_W + 1)'(PKTLEN_LIMIT)))
                    ? '0 : len_sum[PKTLEN_W-1:0];

   assign status.extra     = extra;
   assign status.has_pts   = has_pts_ff;
   assign status.send_dts  = send_dts_ff;
   assign status.has_priv  = priv_ff != '0;
   assign status.has_stuff = stuff_ff != '0;
   assign status.priv_len  = priv_ff;
   assign status.stuff_len = stuff_ff;

   assign ts     = ctrl.use_dts ? dts_ff : pts_ff;
   assign ts_nib = ctrl.use_dts ? 4'b0001 : {3'b001, send_dts_ff};

   always_comb begin
      unique case (ctrl.src)
         SRC_ZERO:    out_byte = 8'h00;
         SRC_ONE:     out_byte = 8'h01;
         SRC_SID:     out_byte = stream_id;
         SRC_LENH:    out_byte = len_ff[15:8];
         SRC_LENL:    out_byte = len_ff[7:0];
         SRC_FLAG0:   out_byte = {5'b10000, data_alignment, 2'b00};
         SRC_FLAGS:   out_byte = {has_pts_ff, send_dts_ff, 5'b00000, priv_ff != '0};
         SRC_HLEN:    out_byte = BYTE_W'(hlen_ff);
         SRC_TS0:     out_byte = {ts_nib, ts[32:30], 1'b1};
         SRC_TS1:     out_byte = ts[29:22];
         SRC_TS2:     out_byte = {ts[21:15], 1'b1};
         SRC_TS3:     out_byte = ts[14:7];
         SRC_TS4:     out_byte = {ts[6:0], 1'b1};
         SRC_PRIVHDR: out_byte = PRIV_MARKER;
         SRC_PRIV:    out_byte = priv_rd_ff;
         SRC_STUFF:   out_byte = STUFF_BYTE;
         SRC_DATA:    out_byte = data_ff;
         default:     out_byte = 8'h00;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/pes_header_packetizer.sv
// pes packet builder, byte stream out
//
// req channel: one transaction per command, command in req_tuser. a load
// transaction writes one private byte and makes no output. a payload
// transaction makes one rsp byte with rsp_tlast set. a header transaction
// makes the whole header run (6 to 64 bytes), rsp_tlast on its final byte.
// csr channel: register writes (stream id, alignment, stuffing), always ready,
// to be used only while no run is in progress.
// a run's first byte goes from the req transaction through the sequencer
// step register into the rsp register. payload bytes flow at one per cycle
// while rsp is ready; a header run emits one byte per step, with an empty
// step for each optional section skipped before its last byte (at most four).
// a new req transaction is taken in the cycle the current run hands over its
// last byte, so runs follow each other without a gap.
// when rsp stalls the sequencer holds its step and the rsp register holds
// its byte; nothing is dropped. reset clears the sequencer and the rsp
// valid flag and sets the csr registers to their defaults; the private buffer
// is not cleared.
`default_nettype none

module pes_header_packetizer #(
   parameter int PRIVATE_MAX = peshp_pkg::PRIVATE_MAX_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata, low bit up: data_byte, byte_index, has_pts, pts_value,
   // has_dts, dts_value, payload_length, private_length, zero pad
   input  wire logic [peshp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: command
   input  wire logic [peshp_pkg::CMD_W-1:0]         req_tuser,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // rsp_tdata: out_byte; rsp_tlast: last_of_run
   output logic [peshp_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [peshp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [peshp_pkg::BYTE_W-1:0]        csr_data
);
   import peshp_pkg::*;

   // configuration registers
   logic [BYTE_W-1:0] sid_ff;
   logic              align_ff;
   logic [CNT_W-1:0]  stuffing_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_acc, start_hdr, start_pay, load;
   logic              out_free, emit, last, busy, done_now;
   logic [BYTE_W-1:0] dp_byte;
   seq_ctrl_type      ctrl;
   dp_status_type     status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sid_ff      <= 8'hE0;
         align_ff    <= 1'b0;
         stuffing_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_STREAM_ID: sid_ff      <= csr_data;
            REG_ALIGN:     align_ff    <= csr_data[0];
            REG_STUFFING:  stuffing_ff <= csr_data[CNT_W-1:0];
            default:       ;
         endcase
      end
   end

   // new item when idle, or in the cycle the run hands over its last byte
   assign req_tready = ~busy | done_now;
   assign req_acc    = req_tvalid & req_tready;
   assign start_hdr  = req_acc & (req_tuser == CMD_HEADER);
   assign start_pay  = req_acc & (req_tuser == CMD_PAYLOAD);
   assign load       = req_acc & (req_tuser == CMD_LOAD);

   assign out_free = ~rsp_valid_ff | rsp_tready;

   peshp_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .start_hdr (start_hdr),
      .start_pay (start_pay),
      .out_free  (out_free),
      .status    (status),
      .ctrl      (ctrl),
      .emit      (emit),
      .last      (last),
      .busy      (busy),
      .done_now  (done_now)
   );

   peshp_datapath #(
      .PRIVATE_MAX (PRIVATE_MAX)
   ) u_dp (
      .clock           (clock),
      .start_hdr       (start_hdr),
      .start_pay       (start_pay),
      .load            (load),
      .data_byte       (req_tdata[7:0]),
      .byte_index      (req_tdata[11:8]),
      .has_pts         (req_tdata[12]),
      .pts_value       (req_tdata[45:13]),
      .has_dts         (req_tdata[46]),
      .dts_value       (req_tdata[79:47]),
      .payload_length  (req_tdata[103:80]),
      .private_length  (req_tdata[108:104]),
      .stream_id       (sid_ff),
      .data_alignment  (align_ff),
      .stuffing_length (stuffing_ff),
      .ctrl            (ctrl),
      .status          (status),
      .out_byte        (dp_byte)
   );

   // rsp register, loaded whenever the sequencer emits
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = dp_byte;
         rsp_last_in  = last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !emit)
      else $error("rsp byte overwritten while stalled");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !done_now) |-> !busy)
      else $error("request taken during a run");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (emit && last && !req_acc) |=> !busy)
      else $error("run continues after its last byte");

endmodule

`default_nettype wire

>>> sim/tb_pes_header_packetizer.sv
`timescale 1ns / 100ps

module tb_pes_header_packetizer;
   import peshp_pkg::*;

   // command 3 has no meaning, the block must drop it
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // header flag bits and timestamp marker nibbles
   localparam logic [7:0] FLAG0_BASE = 8'h80;
   localparam logic [7:0] FLAG_PTS   = 8'h80;
   localparam logic [7:0] FLAG_DTS   = 8'h40;
   localparam logic [7:0] FLAG_PRIV  = 8'h01;
   localparam logic [3:0] TAG_PTS_ONLY     = 4'h2;
   localparam logic [3:0] TAG_PTS_WITH_DTS = 4'h3;
   localparam logic [3:0] TAG_DTS          = 4'h1;

   localparam logic [32:0] STAMP_MAX   = 33'h1_FFFF_FFFF;
   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int          MAX_REPORTS = 10;

   // one req transaction, all fields unpacked
   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [7:0]        data;
      logic [3:0]        idx;
      logic              has_pts;
      logic [TS_W-1:0]   pts;
      logic              has_dts;
      logic [TS_W-1:0]   dts;
      logic [PLEN_W-1:0] plen;
      logic [4:0]        priv_len;
   } pes_cmd_type;

   // one packet byte still to come out of rsp
   typedef struct {
      logic [7:0] value;
      logic       last;
   } pes_byte_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [BYTE_W-1:0]     csr_data = '0;

   // shadow of the block's registers and private buffer
   logic [7:0] cfg_stream_id = 8'hE0;
   logic       cfg_align     = 1'b0;
   logic [4:0] cfg_stuffing  = 5'd0;
   logic [7:0] priv_shadow [PRIVATE_MAX_DEF];

   logic [7:0]   packet_run [$];
   pes_byte_type pes_bytes_due [$];
   pes_byte_type due_byte;

   int fail_cnt        = 0;
   int byte_cnt        = 0;
   int cycle_cnt       = 0;
   int rsp_hold_cycles = 0;
   bit no_idle         = 1'b0;

   pes_header_packetizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // five timestamp bytes: tag and bits 32..30, then two 15-bit groups, marker bits set
   function automatic void push_stamp(input logic [3:0] tag, input logic [TS_W-1:0] ts);
      packet_run.push_back({tag, ts[32:30], 1'b1});
      packet_run.push_back(ts[29:22]);
      packet_run.push_back({ts[21:15], 1'b1});
      packet_run.push_back(ts[14:7]);
      packet_run.push_back({ts[6:0], 1'b1});
   endfunction

   // works out the bytes one accepted transaction must produce, queues them
   function automatic void build_packet_bytes(input pes_cmd_type c);
      logic [4:0]   priv_n;
      logic [4:0]   stuff_n;
      logic         send_dts;
      logic         ext;
      logic [7:0]   flags;
      logic [7:0]   hlen;
      int unsigned  pkt_len;
      pes_byte_type b;
      packet_run.delete();
      case (c.cmd)
         CMD_LOAD: begin
            priv_shadow[c.idx] = c.data;
         end
         CMD_PAYLOAD: begin
            packet_run.push_back(c.data);
         end
         CMD_HEADER: begin
            priv_n = c.priv_len;
            if (priv_n > PRIVATE_MAX_DEF) priv_n = 5'(PRIVATE_MAX_DEF);
            stuff_n = (cfg_stuffing > STUFF_MAX) ? STUFF_MAX : cfg_stuffing;
            send_dts = c.has_pts && c.has_dts && (c.dts != c.pts);
            ext = (cfg_stream_id != SID_NO_EXT);
            hlen = {3'b000, stuff_n};
            flags = 8'h00;
            if (c.has_pts) begin
               hlen += 8'd5;
               flags |= FLAG_PTS;
            end
            if (send_dts) begin
               hlen += 8'd5;
               flags |= FLAG_DTS;
            end
            if (priv_n != 0) begin
               hlen += 8'd1 + {3'b000, priv_n};
               flags |= FLAG_PRIV;
            end
            // length field is zero when plen is zero or when it cannot hold the packet
            pkt_len = 0;
            if (c.plen != 0) begin
               pkt_len = 32'(c.plen) + 32'(hlen) + (ext ? 32'd3 : 32'd0);
               if (pkt_len > PKTLEN_LIMIT) pkt_len = 0;
            end
            // start code prefix, stream id and packet length
            packet_run.push_back(8'h00);
            packet_run.push_back(8'h00);
            packet_run.push_back(8'h01);
            packet_run.push_back(cfg_stream_id);
            packet_run.push_back(pkt_len[15:8]);
            packet_run.push_back(pkt_len[7:0]);
            if (ext) begin
               packet_run.push_back(FLAG0_BASE | {5'b00000, cfg_align, 2'b00});
               packet_run.push_back(flags);
               packet_run.push_back(hlen);
            end
            if (c.has_pts) push_stamp(send_dts ? TAG_PTS_WITH_DTS : TAG_PTS_ONLY, c.pts);
            if (send_dts) push_stamp(TAG_DTS, c.dts);
            if (priv_n != 0) begin
               packet_run.push_back(PRIV_MARKER);
               for (int i = 0; i < priv_n; i++) packet_run.push_back(priv_shadow[i]);
            end
            for (int i = 0; i < stuff_n; i++) packet_run.push_back(STUFF_BYTE);
         end
         default: ;
      endcase
      foreach (packet_run[i]) begin
         b.value = packet_run[i];
         b.last  = (i == packet_run.size() - 1);
         pes_bytes_due.push_back(b);
      end
   endfunction

   function automatic logic [TS_W-1:0] rand_stamp();
      logic [TS_W-1:0] v;
      v[31:0] = $urandom();
      v[32]   = 1'($urandom_range(0, 1));
      return v;
   endfunction

   // every field random, so that unused fields toggle too
   function automatic pes_cmd_type random_fields();
      pes_cmd_type c;
      logic [31:0] r;
      r = $urandom();
      c.cmd      = CMD_W'($urandom_range(0, 3));
      c.data     = r[7:0];
      c.idx      = r[11:8];
      c.has_pts  = r[12];
      c.has_dts  = r[13];
      c.priv_len = r[18:14];
      c.pts      = rand_stamp();
      c.dts      = rand_stamp();
      r = $urandom();
      c.plen     = r[23:0];
      return c;
   endfunction

   function automatic pes_cmd_type load_cmd(input logic [3:0] idx, input logic [7:0] data);
      pes_cmd_type c;
      c = random_fields();
      c.cmd  = CMD_LOAD;
      c.idx  = idx;
      c.data = data;
      return c;
   endfunction

   function automatic pes_cmd_type payload_cmd(input logic [7:0] data);
      pes_cmd_type c;
      c = random_fields();
      c.cmd  = CMD_PAYLOAD;
      c.data = data;
      return c;
   endfunction

   function automatic pes_cmd_type header_cmd(input logic hp, input logic [TS_W-1:0] pts,
                                              input logic hd, input logic [TS_W-1:0] dts,
                                              input logic [PLEN_W-1:0] plen,
                                              input logic [4:0] priv);
      pes_cmd_type c;
      c = random_fields();
      c.cmd      = CMD_HEADER;
      c.has_pts  = hp;
      c.pts      = pts;
      c.has_dts  = hd;
      c.dts      = dts;
      c.plen     = plen;
      c.priv_len = priv;
      return c;
   endfunction

   // offers one req transaction, maybe after a short gap, and predicts on accept
   task automatic send_item(input pes_cmd_type c);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.cmd;
      // zero pad, private_length, payload_length, dts, has_dts, pts, has_pts,
      // byte_index, data_byte
      req_tdata  <= {3'b000, c.priv_len, c.plen, c.dts, c.has_dts, c.pts, c.has_pts,
                     c.idx, c.data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      build_packet_bytes(c);
   endtask

   // sender stops and waits until every predicted byte has come out
   task automatic drain_pending();
      req_tvalid <= 1'b0;
      while (pes_bytes_due.size() != 0) @(posedge clock);
   endtask

   // loads leave no trace on rsp, so give a trailing one time to settle
   task automatic wait_idle();
      drain_pending();
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_STREAM_ID: cfg_stream_id = val;
         REG_ALIGN:     cfg_align     = val[0];
         REG_STUFFING:  cfg_stuffing  = val[4:0];
         default: ;
      endcase
   endtask

   task automatic program_regs(input logic [7:0] sid, input logic align,
                               input logic [4:0] stuff);
      csr_write(REG_STREAM_ID, sid);
      csr_write(REG_ALIGN, {7'b0000000, align});
      csr_write(REG_STUFFING, {3'b000, stuff});
      csr_valid <= 1'b0;
   endtask

   // a header with some loads ahead and payload bytes behind, now and then broken
   task automatic send_random_packet(output int n_sent);
      pes_cmd_type c;
      int          n_pay;
      logic [31:0] r;
      n_sent = 0;
      repeat ($urandom_range(0, 2)) begin
         c = random_fields();
         c.cmd = CMD_LOAD;
         send_item(c);
         n_sent++;
      end
      // stray unknown command
      if ($urandom_range(0, 9) == 0) begin
         c = random_fields();
         c.cmd = CMD_UNUSED;
         send_item(c);
      end
      n_pay = $urandom_range(0, 6);
      // a tenth of the packets lose their header
      if ($urandom_range(0, 9) != 0) begin
         c = random_fields();
         c.cmd = CMD_HEADER;
         if ($urandom_range(0, 3) == 0) c.dts = c.pts;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: c.priv_len = 5'd0;
            5, 6, 7, 8:    c.priv_len = 5'($urandom_range(1, PRIVATE_MAX_DEF));
            default:       c.priv_len = 5'($urandom_range(PRIVATE_MAX_DEF + 1, 31));
         endcase
         r = $urandom();
         case ($urandom_range(0, 4))
            0: c.plen = '0;
            1: c.plen = PLEN_W'(n_pay);
            2: c.plen = PLEN_W'($urandom_range(1, 2000));
            3: c.plen = PLEN_W'($urandom_range(65400, 65535));
            default: c.plen = r[23:0];
         endcase
         send_item(c);
         n_sent++;
      end
      repeat (n_pay) begin
         c = random_fields();
         c.cmd = CMD_PAYLOAD;
         send_item(c);
         n_sent++;
      end
   endtask

   // fill every buffer entry so that no header ever reads an unwritten one
   task automatic test_private_buffer();
      for (int i = 0; i < PRIVATE_MAX_DEF; i++) begin
         if (i == 0) send_item(load_cmd(4'(i), 8'h00));
         else if (i == PRIVATE_MAX_DEF - 1) send_item(load_cmd(4'(i), 8'hFF));
         else send_item(load_cmd(4'(i), 8'($urandom_range(0, 255))));
      end
   endtask

   // header sections one by one, at reset register values
   task automatic test_header_fields();
      pes_cmd_type c;
      // bare header, no payload
      send_item(header_cmd(1'b0, '0, 1'b0, '0, '0, 5'd0));
      send_item(header_cmd(1'b1, STAMP_MAX, 1'b0, '0, 24'd1, 5'd0));
      // length just fits, then one past it
      send_item(header_cmd(1'b1, STAMP_MAX, 1'b1, '0, 24'h00FFF2, 5'd0));
      send_item(header_cmd(1'b1, '0, 1'b1, STAMP_MAX, 24'h00FFF3, 5'd0));
      // dts equal to pts is dropped
      send_item(header_cmd(1'b1, 33'h0_5555_5555, 1'b1, 33'h0_5555_5555, 24'd100, 5'd1));
      // dts without pts is dropped
      send_item(header_cmd(1'b0, '0, 1'b1, STAMP_MAX, 24'd5, 5'd16));
      // private length beyond the buffer saturates
      send_item(header_cmd(1'b1, 33'h1_AAAA_AAAA, 1'b0, '0, 24'hFFFFFF, 5'd31));
      send_item(payload_cmd(8'h00));
      send_item(payload_cmd(8'hFF));
      c = random_fields();
      c.cmd = CMD_UNUSED;
      send_item(c);
   endtask

   // longest runs, stream id without extension, stuffing saturation
   task automatic test_register_extremes();
      wait_idle();
      program_regs(8'h00, 1'b1, 5'd28);
      send_item(header_cmd(1'b1, STAMP_MAX, 1'b1, '0, 24'd1, 5'd16));
      wait_idle();
      program_regs(SID_NO_EXT, 1'b1, 5'd31);
      send_item(header_cmd(1'b1, '0, 1'b1, STAMP_MAX, 24'h00FFFF, 5'd31));
      send_item(header_cmd(1'b0, '0, 1'b0, '0, '0, 5'd0));
      wait_idle();
      program_regs(8'hFF, 1'b0, 5'd0);
      send_item(header_cmd(1'b1, 33'h1_0000_0000, 1'b0, '0, 24'd7, 5'd2));
      send_item(payload_cmd(8'hA5));
   endtask

   // random packets over several register settings
   task automatic test_random_traffic();
      int n;
      int sent;
      for (int phase = 0; phase < 5; phase++) begin
         wait_idle();
         if (phase == 0) program_regs(8'hE0, 1'b0, 5'd0);
         else program_regs(($urandom_range(0, 3) == 0) ? SID_NO_EXT
                                                       : 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
         sent = 0;
         while (sent < 40) begin
            send_random_packet(n);
            sent += n;
         end
      end
   endtask

   // rsp held off for a long stretch while req keeps offering, block must back up
   task automatic test_output_stall();
      pes_cmd_type c;
      rsp_hold_cycles = 400;
      for (int i = 0; i < 24; i++) begin
         c = random_fields();
         c.cmd = ($urandom_range(0, 1) != 0) ? CMD_HEADER : CMD_PAYLOAD;
         send_item(c);
      end
      drain_pending();
   endtask

   // last part: no gaps on either side
   task automatic test_back_to_back();
      int n;
      int sent;
      no_idle = 1'b1;
      sent = 0;
      while (sent < 45) begin
         send_random_packet(n);
         sent += n;
      end
   endtask

   // rsp side: random stall bursts, plus a long hold when a test asks for one
   initial begin : rsp_side
      int hold_n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            hold_n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_tready <= 1'b0;
            repeat (hold_n) @(posedge clock);
         end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // each rsp transaction against the oldest predicted byte
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pes_bytes_due.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
               $display("byte %0d: none expected, got %02h tlast %0b",
                        byte_cnt, rsp_tdata, rsp_tlast);
         end else begin
            due_byte = pes_bytes_due.pop_front();
            if (rsp_tdata !== due_byte.value || rsp_tlast !== due_byte.last) begin
               fail_cnt++;
               if (fail_cnt <= MAX_REPORTS)
                  $display("byte %0d: expected %02h tlast %0b, got %02h tlast %0b",
                           byte_cnt, due_byte.value, due_byte.last, rsp_tdata, rsp_tlast);
            end
         end
         byte_cnt++;
      end
   end

   // hard stop if the block hangs
   initial begin : watchdog
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("timeout after %0d cycles, %0d bytes pending", cycle_cnt, pes_bytes_due.size());
      $display("pes_header_packetizer regression: fail");
      $finish;
   end

   initial begin : main
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_private_buffer();
      test_header_fields();
      test_register_extremes();
      test_random_traffic();
      test_output_stall();
      test_back_to_back();
      drain_pending();
      repeat (16) @(posedge clock);
      if (pes_bytes_due.size() != 0) begin
         fail_cnt++;
         $display("%0d predicted bytes never came out", pes_bytes_due.size());
      end
      if (fail_cnt == 0) begin
         $display("pes_header_packetizer regression: pass");
      end else begin
         $display("pes_header_packetizer regression: fail");
      end
      $finish;
   end

endmodule
